FILE: hdl/msrc_pkg.sv
// msrc_pkg: shared types and constants of the momentum sector representative check
// payload structs, verdict and register codes, controller/datapath command and status
// no dependencies
package msrc_pkg;

	localparam int MaxSitesDefault = 16;
	localparam int PatternW = 32;
	localparam int VerdictW = 2;
	localparam int PeriodW = 5;
	localparam int NormW = 9;
	localparam int IndexW = 32;
	localparam int ChainLenW = 5;
	localparam int FillW = 6;
	localparam int MomentumW = 4;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 6;

	// verdict codes
	localparam logic [VerdictW-1:0] VerdictKept = 2'd0;
	localparam logic [VerdictW-1:0] VerdictFilling = 2'd1;
	localparam logic [VerdictW-1:0] VerdictNotRep = 2'd2;
	localparam logic [VerdictW-1:0] VerdictMomentum = 2'd3;

	// register indexes
	localparam logic [CfgIdxW-1:0] RegChainLength = 2'd0;
	localparam logic [CfgIdxW-1:0] RegNumUp = 2'd1;
	localparam logic [CfgIdxW-1:0] RegNumDn = 2'd2;
	localparam logic [CfgIdxW-1:0] RegMomentum = 2'd3;

	localparam logic [ChainLenW-1:0] ChainLengthReset = 5'd4;

	typedef struct packed {
		logic [PatternW-1:0] up_pattern;
		logic [PatternW-1:0] dn_pattern;
	} msrc_in_t;

	typedef struct packed {
		logic [VerdictW-1:0] verdict;
		logic [PeriodW-1:0]  period;
		logic [NormW-1:0]    norm;
		logic [IndexW-1:0]   basis_index;
	} msrc_out_t;

	typedef struct packed {
		logic                load;      // latch the pair and set the step count to 1
		logic                step;      // advance one translation
		logic                set_full;  // no return: period is the chain length
		logic                set_ret;   // returned: latch period, start quotient
		logic                div;       // one quotient subtraction
		logic                mod_init;  // load momentum into the remainder
		logic                mod;       // one remainder subtraction
		logic                out_wr;    // write the result register
		logic [VerdictW-1:0] verdict;
	} msrc_cmd_t;

	typedef struct packed {
		logic bad_in;
		logic step_end;
		logic less;
		logic equal;
		logic div_done;
		logic mod_done;
		logic mod_zero;
	} msrc_sts_t;

endpackage

FILE: hdl/momentum_sector_representative_check_core.sv
// Momentum sector representative check, top level.
// Pairs (up_pattern, dn_pattern) enter on in_valid/in_ready; one result per pair
// leaves on out_valid/out_ready: verdict, period, norm and running basis index.
// Registers chain_length, num_up, num_dn, momentum are written on cfg_valid with
// cfg_index 0..3; cfg_ready is always high. Write them only while the block is idle.
// A pair with wrong filling goes from acceptance to the done state and then into the
// result register. Otherwise the translation loop runs one step per cycle until the
// first return or smaller translate, or until all L-1 translations are checked. On a
// return at period R, the quotient L/R is counted by repeated subtraction, and the
// remainder momentum mod (L/R) follows on the same subtractor; the done state then
// loads the result register. One pair is in work at a time, and in_ready is high
// only while the sequencer is idle.
// The result register holds a finished transaction while the receiver stalls; the
// sequencer accepts the next pair meanwhile and waits only when a second result is due.
// Reset (arst_n low) restores chain_length 4, other registers 0, clears the kept
// counter and drops any pending result.
module momentum_sector_representative_check_core #(
	parameter int MAX_SITES = msrc_pkg::MaxSitesDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  msrc_pkg::msrc_in_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output msrc_pkg::msrc_out_t            out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [msrc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [msrc_pkg::CfgDataW-1:0]  cfg_data
);

	msrc_pkg::msrc_cmd_t cmd;
	msrc_pkg::msrc_sts_t sts;

	assign cfg_ready = 1'b1;

	msrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	msrc_datapath #(
		.MAX_SITES (MAX_SITES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

FILE: hdl/msrc_ctrl.sv
// msrc_ctrl: sequencing state machine of the representative check
// drives msrc_cmd_t from msrc_sts_t and owns the handshakes; uses msrc_pkg
module msrc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  msrc_pkg::msrc_sts_t  sts,
	output msrc_pkg::msrc_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP,
		S_DIV,
		S_MOD,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic [msrc_pkg::VerdictW-1:0] verdict_q;
	logic [msrc_pkg::VerdictW-1:0] verdict_d;
	logic out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.verdict = verdict_q;
		state_d = state_q;
		verdict_d = verdict_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.bad_in) begin
						verdict_d = msrc_pkg::VerdictFilling;
						state_d = S_DONE;
					end else begin
						state_d = S_STEP;
					end
				end
			end
			S_STEP: begin
				if (sts.step_end) begin
					cmd.set_full = 1'b1;
					verdict_d = msrc_pkg::VerdictKept;
					state_d = S_DONE;
				end else if (sts.less) begin
					verdict_d = msrc_pkg::VerdictNotRep;
					state_d = S_DONE;
				end else if (sts.equal) begin
					cmd.set_ret = 1'b1;
					state_d = S_DIV;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.mod_init = 1'b1;
					state_d = S_MOD;
				end else begin
					cmd.div = 1'b1;
				end
			end
			S_MOD: begin
				if (sts.mod_done) begin
					verdict_d = sts.mod_zero ? msrc_pkg::VerdictKept
						: msrc_pkg::VerdictMomentum;
					state_d = S_DONE;
				end else begin
					cmd.mod = 1'b1;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_wr = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			verdict_q <= msrc_pkg::VerdictKept;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			verdict_q <= verdict_d;
			if (cmd.out_wr) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/msrc_datapath.sv
// msrc_datapath: configuration registers, translation registers, shared subtractor
// for quotient and remainder, kept counter and result register; uses msrc_pkg
module msrc_datapath #(
	parameter int MAX_SITES = msrc_pkg::MaxSitesDefault
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [msrc_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [msrc_pkg::CfgDataW-1:0]       cfg_data,
	input  msrc_pkg::msrc_in_t                  in_data,
	input  msrc_pkg::msrc_cmd_t                 cmd,
	output msrc_pkg::msrc_sts_t                 sts,
	output msrc_pkg::msrc_out_t                 out_data
);

	localparam int H = MAX_SITES;
	localparam int LW = $clog2(MAX_SITES + 1);
	localparam int IW = $clog2(MAX_SITES);
	localparam int AW = (LW > msrc_pkg::MomentumW) ? LW : msrc_pkg::MomentumW;
	localparam int PW = msrc_pkg::PatternW;

	logic [msrc_pkg::ChainLenW-1:0] chain_length_q;
	logic [msrc_pkg::FillW-1:0]     num_up_q;
	logic [msrc_pkg::FillW-1:0]     num_dn_q;
	logic [msrc_pkg::MomentumW-1:0] momentum_q;

	logic [LW-1:0]    len;
	logic [H-1:0]     mask;
	logic             ovf;
	logic [PW-1:0]    up_sh;
	logic [PW-1:0]    dn_sh;
	logic [4*H-1:0]   load_val;
	logic [4*H-1:0]   nxt;

	logic [4*H-1:0]   orig_q;
	logic [4*H-1:0]   cur_q;
	logic [LW-1:0]    r_q;
	logic [LW-1:0]    period_q;
	logic [LW-1:0]    q_q;
	logic [AW-1:0]    a_q;
	logic [msrc_pkg::IndexW-1:0] kept_q;
	msrc_pkg::msrc_out_t out_q;
	logic [2*LW-1:0]  norm_prod;

	function automatic logic [msrc_pkg::FillW-1:0] popcnt(input logic [PW-1:0] v);
		logic [msrc_pkg::FillW-1:0] c;
		c = '0;
		for (int i = 0; i < PW; i++) begin
			c = c + msrc_pkg::FillW'(v[i]);
		end
		return c;
	endfunction

	// one-site cyclic shift of a half of width l
	function automatic logic [H-1:0] rot(input logic [H-1:0] h, input logic [LW-1:0] l);
		logic [H-1:0]  res;
		logic [LW-1:0] lm1;
		logic [IW-1:0] top;
		lm1 = l - LW'(1);
		top = lm1[IW-1:0];
		res = {h[H-2:0], h[top]};
		for (int i = 0; i < H; i++) begin
			if (i >= int'(l)) begin
				res[i] = 1'b0;
			end
		end
		return res;
	endfunction

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_length_q <= msrc_pkg::ChainLengthReset;
			num_up_q <= '0;
			num_dn_q <= '0;
			momentum_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				msrc_pkg::RegChainLength: chain_length_q <= cfg_data[msrc_pkg::ChainLenW-1:0];
				msrc_pkg::RegNumUp:       num_up_q <= cfg_data;
				msrc_pkg::RegNumDn:       num_dn_q <= cfg_data;
				msrc_pkg::RegMomentum:    momentum_q <= cfg_data[msrc_pkg::MomentumW-1:0];
				default: ;
			endcase
		end
	end

	// effective chain length, clamped to 1..MAX_SITES
	always_comb begin
		if (chain_length_q == '0) begin
			len = LW'(1);
		end else if (chain_length_q > msrc_pkg::ChainLenW'(MAX_SITES)) begin
			len = LW'(MAX_SITES);
		end else begin
			len = LW'(chain_length_q);
		end
	end

	always_comb begin
		ovf = 1'b0;
		for (int i = 0; i < H; i++) begin
			mask[i] = (i < int'(len));
		end
		for (int i = 0; i < PW; i++) begin
			if (i >= 2 * int'(len)) begin
				ovf = ovf | in_data.up_pattern[i] | in_data.dn_pattern[i];
			end
		end
		up_sh = in_data.up_pattern >> len;
		dn_sh = in_data.dn_pattern >> len;
		// {up hi, up lo, dn hi, dn lo}: orders like the full (up, dn) pair
		load_val = {up_sh[H-1:0] & mask, in_data.up_pattern[H-1:0] & mask,
			dn_sh[H-1:0] & mask, in_data.dn_pattern[H-1:0] & mask};
		nxt = {rot(cur_q[4*H-1:3*H], len), rot(cur_q[3*H-1:2*H], len),
			rot(cur_q[2*H-1:H], len), rot(cur_q[H-1:0], len)};
	end

	assign sts.bad_in = ovf || (popcnt(in_data.up_pattern) != num_up_q)
		|| (popcnt(in_data.dn_pattern) != num_dn_q);
	assign sts.step_end = (r_q >= len);
	assign sts.less = (nxt < orig_q);
	assign sts.equal = (nxt == orig_q);
	assign sts.div_done = (a_q == '0);
	assign sts.mod_done = (a_q < AW'(q_q));
	assign sts.mod_zero = (a_q == '0);

	// period divides the length, so norm is length times quotient
	assign norm_prod = (2*LW)'(len) * (2*LW)'(q_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			orig_q <= load_val;
			cur_q <= load_val;
			r_q <= LW'(1);
		end
		if (cmd.step) begin
			cur_q <= nxt;
			r_q <= r_q + LW'(1);
		end
		if (cmd.set_full) begin
			period_q <= len;
			q_q <= LW'(1);
		end
		if (cmd.set_ret) begin
			period_q <= r_q;
			q_q <= '0;
			a_q <= AW'(len);
		end
		if (cmd.div) begin
			a_q <= a_q - AW'(period_q);
			q_q <= q_q + LW'(1);
		end
		if (cmd.mod_init) begin
			a_q <= AW'(momentum_q);
		end
		if (cmd.mod) begin
			a_q <= a_q - AW'(q_q);
		end
		if (cmd.out_wr) begin
			out_q.verdict <= cmd.verdict;
			if (cmd.verdict == msrc_pkg::VerdictKept) begin
				out_q.period <= msrc_pkg::PeriodW'(period_q);
				out_q.norm <= msrc_pkg::NormW'(norm_prod);
				out_q.basis_index <= kept_q;
			end else begin
				out_q.period <= '0;
				out_q.norm <= '0;
				out_q.basis_index <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= '0;
		end else if (cmd.out_wr && (cmd.verdict == msrc_pkg::VerdictKept)) begin
			kept_q <= kept_q + msrc_pkg::IndexW'(1);
		end
	end

	assign out_data = out_q;

endmodule
